// ===== hw/rtl/csvfs_pkg.sv =====
// Shared types and constants of the field splitter.
// Holds the character codes, result kind codes, the parser state struct and
// the result record. No dependencies.
package csvfs_pkg;

    // Character codes the parser reacts to.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Reset value of the delimiter register, a comma.
    localparam logic [7:0] DELIM_RESET = 8'd44;

    // Result kind codes.
    localparam logic [1:0] KIND_BYTE       = 2'd0;
    localparam logic [1:0] KIND_FIELD_END  = 2'd1;
    localparam logic [1:0] KIND_RECORD_END = 2'd2;

    // Depth of the result queue; two results per item plus one to keep
    // single-result items flowing at one per cycle when the output is not stalled.
    localparam int unsigned QDEPTH = 3;

    // Parser state carried from one item to the next.
    typedef struct packed {
        logic in_quote;
        logic quote_pending;
        logic field_nonempty;
        logic trim_done;
        logic line_done;
    } t_state;

    // One result record.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic       last;
    } t_result;

endpackage

// ===== hw/rtl/csvfs_decode.sv =====
// Per-item decision logic of the field splitter.
// Takes one registered item and the current parser state and gives the next
// state and up to two results. Depends on csvfs_pkg.
module csvfs_decode (
    input  csvfs_pkg::t_state  i_state,
    input  logic [7:0]         i_delim,
    input  logic [7:0]         i_in_byte,
    input  logic               i_byte_valid,
    input  logic               i_line_end,
    output csvfs_pkg::t_state  o_state,
    output logic [1:0]         o_nres,
    output csvfs_pkg::t_result o_res0,
    output csvfs_pkg::t_result o_res1
);
    import csvfs_pkg::*;

    t_state     s;
    logic       unquoted;
    logic       content;
    logic       have;
    logic [1:0] have_kind;
    logic [7:0] have_byte;

    // Byte handling, then the line end, in the order the format defines.
    always_comb begin
        s         = i_state;
        unquoted  = 1'b0;
        content   = 1'b0;
        have      = 1'b0;
        have_kind = KIND_BYTE;
        have_byte = 8'h00;

        if (i_byte_valid && !i_state.line_done) begin
            if (i_state.quote_pending) begin
                // A quote waited for this byte: a second quote is a literal.
                s.quote_pending = 1'b0;
                if (i_in_byte == CH_QUOTE) begin
                    content = 1'b1;
                end else begin
                    s.in_quote = 1'b0;
                    unquoted   = 1'b1;
                end
            end else if (i_state.in_quote) begin
                if (i_in_byte == CH_NUL) begin
                    s.line_done = 1'b1;
                end else if (i_in_byte == CH_QUOTE) begin
                    s.quote_pending = 1'b1;
                end else begin
                    content = 1'b1;
                end
            end else begin
                unquoted = 1'b1;
            end

            // Byte seen outside quotes.
            if (unquoted) begin
                if (i_in_byte == CH_NUL) begin
                    s.line_done = 1'b1;
                end else if (i_in_byte == CH_QUOTE && !s.field_nonempty) begin
                    s.in_quote = 1'b1;
                end else if (i_in_byte == i_delim) begin
                    have             = 1'b1;
                    have_kind        = KIND_FIELD_END;
                    s.field_nonempty = 1'b0;
                    s.trim_done      = 1'b0;
                end else if (i_in_byte inside {CH_CR, CH_LF}) begin
                    s.line_done = 1'b1;
                end else begin
                    content = 1'b1;
                end
            end

            // Content byte: leading blanks are dropped but mark the field.
            if (content) begin
                s.field_nonempty = 1'b1;
                if (s.trim_done || !(i_in_byte inside {CH_SPACE, CH_TAB})) begin
                    s.trim_done = 1'b1;
                    have        = 1'b1;
                    have_kind   = KIND_BYTE;
                    have_byte   = i_in_byte;
                end
            end
        end

        // The line end item closes the record and clears the state.
        if (i_line_end) begin
            s = '0;
        end
    end

    // Result assembly.
    always_comb begin
        o_state       = s;
        o_nres        = {1'b0, have} + {1'b0, i_line_end};
        o_res0        = '0;
        o_res1        = '0;
        o_res1.kind   = KIND_RECORD_END;
        o_res1.last   = 1'b1;
        if (have) begin
            o_res0.kind     = have_kind;
            o_res0.out_byte = have_byte;
            o_res0.last     = !i_line_end;
        end else begin
            o_res0.kind = KIND_RECORD_END;
            o_res0.last = 1'b1;
        end
    end

endmodule

// ===== hw/rtl/csv_field_splitter.sv =====
// Top level of the field splitter: input register, parser state, result queue.
// Instantiates csvfs_decode; depends on csvfs_pkg.
//
// The splitter takes one byte transaction per cycle, unless o_stall is high,
// into an input register and decides it there, writing its results into a
// three-entry result queue that drives the output port. Items that give zero
// or one result flow at one per cycle when the output is not stalled; an item
// giving two results (a byte or field end with the record end) uses the single
// output port twice, and the input stalls while the queue lacks room for both.
// Items pass through the input register and then the result queue. The
// delimiter register must be written only while the block is idle.
module csv_field_splitter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration.
    input  logic       i_delimiter_we,
    input  logic [7:0] i_delimiter_data,
    // Input channel.
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_byte_valid,
    input  logic       i_line_end,
    // Output channel.
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic       o_last
);
    import csvfs_pkg::*;

    logic [7:0] r_delim;
    t_state     r_state;
    t_state     dec_state;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_byte_valid;
    logic       r_line_end;

    t_result    r_q [QDEPTH];
    t_result    n_q [QDEPTH];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    logic [1:0] nres;
    t_result    res0;
    t_result    res1;
    logic       pop;
    logic       in_accept;
    logic       advance;
    logic [2:0] cnt_pop;

    // Decision logic for the registered item.
    csvfs_decode u_decode (
        .i_state      (r_state),
        .i_delim      (r_delim),
        .i_in_byte    (r_in_byte),
        .i_byte_valid (r_byte_valid),
        .i_line_end   (r_line_end),
        .o_state      (dec_state),
        .o_nres       (nres),
        .o_res0       (res0),
        .o_res1       (res1)
    );

    // Handshake: the item leaves the input register when its results fit.
    assign pop       = o_valid && !i_stall;
    assign cnt_pop   = {1'b0, r_cnt} - {2'b00, pop};
    assign advance   = r_in_valid && ((cnt_pop + {1'b0, nres}) <= 3'(QDEPTH));
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    // Result queue: shift out at the head, append after the remaining entries.
    always_comb begin
        for (int i = 0; i < QDEPTH; i++) begin
            if (pop && (i < QDEPTH - 1)) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (advance && (nres != 2'd0) && (cnt_pop == 3'(i))) begin
                n_q[i] = res0;
            end
            if (advance && (nres == 2'd2) && ((cnt_pop + 3'd1) == 3'(i))) begin
                n_q[i] = res1;
            end
        end
        n_cnt = cnt_pop[1:0] + (advance ? nres : 2'd0);
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim    <= DELIM_RESET;
            r_state    <= '0;
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
        end else begin
            if (i_delimiter_we) begin
                r_delim <= i_delimiter_data;
            end
            if (advance) begin
                r_state <= dec_state;
            end
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            r_cnt <= n_cnt;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte    <= i_in_byte;
            r_byte_valid <= i_byte_valid;
            r_line_end   <= i_line_end;
        end
        for (int i = 0; i < QDEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    // Output port driven from the queue head.
    assign o_valid    = (r_cnt != 2'd0);
    assign o_kind     = r_q[0].kind;
    assign o_out_byte = r_q[0].out_byte;
    assign o_last     = r_q[0].last;

endmodule
